[rtl/bmd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bmd_pkg;

   // width and reset value of the capacity register
   localparam int unsigned CFG_W = 5;
   localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

   // command carried in req_tuser
   typedef enum logic [1:0] {
      CMD_PUSH      = 2'd0,
      CMD_POP_FRONT = 2'd1,
      CMD_POP_BACK  = 2'd2,
      CMD_NOP       = 2'd3
   } cmd_type;

   // status carried in rsp_tuser
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_DUP   = 2'd3
   } status_type;

endpackage : bmd_pkg

`default_nettype wire

[rtl/bounded_monotonic_deque.sv]
`timescale 1ns / 1ps
`default_nettype none
// Bounded monotonic increasing deque, entries held in one ring memory.
// Request channel (req_*): req_tuser carries the command (push, pop front,
// pop back, no-op), req_tdata the signed value to push. Response channel
// (rsp_*): one item per request, rsp_tdata holds the popped value and the
// entry count after the operation, rsp_tuser the status code.
// Capacity is written through csr_wen/csr_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce. Values
// above DEPTH act as DEPTH. A request is taken in the idle cycle. Full pushes,
// empty pops, no-ops and pushes into an empty deque answer in that same cycle
// (the response is registered). A pop reads the memory once. A push onto a
// non-empty deque reads the back entry and then evicts one entry per cycle
// through the registered memory read port. Each entry is evicted at most once.
// The response sits in an output register; the next request is taken while
// it waits. If rsp_tready stays low the finished result is parked and the
// block stops taking requests until the output register drains.
// Reset clears count, front pointer, capacity (to 16) and the output valid;
// the memory itself is not cleared and only written entries are read.
module bounded_monotonic_deque #(
   parameter int unsigned DEPTH      = 16,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // capacity register
   input  wire logic                                   csr_wen,
   input  wire logic [bmd_pkg::CFG_W-1:0]              csr_wdata,
   // request: tdata = value; tuser = command
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]        req_tdata,
   input  wire logic [1:0]                             req_tuser,
   // response: tdata = result_value, entry_count; tuser = status
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic [((DATA_WIDTH+$clog2(DEPTH+1)+7)/8)*8-1:0] rsp_tdata,
   output logic [1:0]                                  rsp_tuser
);
   import bmd_pkg::*;

   localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW    = $clog2(DEPTH + 1);
   localparam int unsigned LW    = (CW > CFG_W) ? CW : CFG_W;
   localparam int unsigned RSP_W = ((DATA_WIDTH + CW + 7) / 8) * 8;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CMP,
      S_POP,
      S_HOLD
   } state_type;

   // ring position of an offset from a base, wrapping at DEPTH
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (AW+1)'(DEPTH))
         sum = sum - (AW+1)'(DEPTH);
      return sum[AW-1:0];
   endfunction

   state_type                     state_ff, state_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [AW-1:0]                 front_ff, front_in;
   logic [CFG_W-1:0]              cap_ff;
   cmd_type                       cmd_ff;
   logic signed [DATA_WIDTH-1:0]  val_ff;

   logic                          rsp_valid_ff;
   logic signed [DATA_WIDTH-1:0]  rsp_value_ff, hold_value_ff;
   status_type                    rsp_status_ff, hold_status_ff;
   logic [CW-1:0]                 rsp_count_ff, hold_count_ff;

   logic signed [DATA_WIDTH-1:0]  entries_mem [DEPTH];
   logic signed [DATA_WIDTH-1:0]  rd_data_ff;
   logic [AW-1:0]                 rd_addr;
   logic                          wr_en;
   logic [AW-1:0]                 wr_addr;
   logic signed [DATA_WIDTH-1:0]  wr_data;

   logic                          fin_go;
   logic signed [DATA_WIDTH-1:0]  fin_value;
   status_type                    fin_status;

   logic                          accept;
   logic                          out_free;
   cmd_type                       req_cmd;
   logic signed [DATA_WIDTH-1:0]  req_val;
   logic [CW-1:0]                 cnt_m1;
   logic [CW-1:0]                 cnt_m2;
   logic [CW-1:0]                 cnt_p1;
   logic [LW-1:0]                 limit;
   logic                          is_full;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_cmd    = cmd_type'(req_tuser);
   assign req_val    = req_tdata[DATA_WIDTH-1:0];

   assign cnt_m1 = count_ff - CW'(1);
   assign cnt_m2 = count_ff - CW'(2);
   assign cnt_p1 = count_ff + CW'(1);

   // effective capacity: the register clipped to DEPTH
   assign limit   = (LW'(cap_ff) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(cap_ff);
   assign is_full = (LW'(count_ff) >= limit);

   // entry ring memory, one write and one registered read port.
   // writes only happen when an item finishes and the next read comes from a
   // later item, so no forwarding is needed
   always_ff @(posedge clock) begin
      if (wr_en)
         entries_mem[wr_addr] <= wr_data;
      rd_data_ff <= entries_mem[rd_addr];
   end

   // next-state, memory access and completion
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      front_in   = front_ff;
      rd_addr    = slot_of(front_ff, cnt_m1[AW-1:0]);
      wr_en      = 1'b0;
      wr_addr    = slot_of(front_ff, count_ff[AW-1:0]);
      wr_data    = val_ff;
      fin_go     = 1'b0;
      fin_value  = '0;
      fin_status = ST_OK;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_PUSH: begin
                     if (is_full) begin
                        fin_go     = 1'b1;
                        fin_status = ST_FULL;
                     end else if (count_ff == '0) begin
                        // empty: append without a read
                        wr_en    = 1'b1;
                        wr_data  = req_val;
                        count_in = CW'(1);
                        fin_go   = 1'b1;
                     end else begin
                        // read the back entry
                        state_in = S_CMP;
                     end
                  end
                  CMD_POP_FRONT, CMD_POP_BACK: begin
                     if (count_ff == '0) begin
                        fin_go     = 1'b1;
                        fin_status = ST_EMPTY;
                     end else begin
                        if (req_cmd == CMD_POP_FRONT)
                           rd_addr = front_ff;
                        state_in = S_POP;
                     end
                  end
                  default: begin
                     fin_go = 1'b1;
                  end
               endcase
            end
         end

         S_CMP: begin
            // rd_data_ff is the entry at count_ff - 1
            if (rd_data_ff > val_ff) begin
               count_in = cnt_m1;
               if (cnt_m1 == '0) begin
                  wr_en    = 1'b1;
                  wr_addr  = front_ff;
                  count_in = CW'(1);
                  fin_go   = 1'b1;
               end else begin
                  rd_addr = slot_of(front_ff, cnt_m2[AW-1:0]);
               end
            end else if (rd_data_ff == val_ff) begin
               fin_go     = 1'b1;
               fin_status = ST_DUP;
            end else begin
               wr_en    = 1'b1;
               count_in = cnt_p1;
               fin_go   = 1'b1;
            end
         end

         S_POP: begin
            fin_go    = 1'b1;
            fin_value = rd_data_ff;
            count_in  = cnt_m1;
            if (cnt_m1 == '0)
               front_in = '0;
            else if (cmd_ff == CMD_POP_FRONT)
               front_in = slot_of(front_ff, AW'(1));
         end

         S_HOLD: begin
            if (out_free)
               state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a finished item either goes out or waits in the hold registers
      if (fin_go)
         state_in = out_free ? S_IDLE : S_HOLD;
   end

   // state, pointers, capacity and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         front_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         front_ff <= front_in;
         if (csr_wen)
            cap_ff <= csr_wdata;

         if (accept) begin
            cmd_ff <= req_cmd;
            val_ff <= req_val;
         end

         if (fin_go && out_free) begin
            rsp_valid_ff  <= 1'b1;
            rsp_value_ff  <= fin_value;
            rsp_status_ff <= fin_status;
            rsp_count_ff  <= count_in;
         end else if (fin_go) begin
            hold_value_ff  <= fin_value;
            hold_status_ff <= fin_status;
            hold_count_ff  <= count_in;
         end else if (state_ff == S_HOLD && out_free) begin
            rsp_valid_ff  <= 1'b1;
            rsp_value_ff  <= hold_value_ff;
            rsp_status_ff <= hold_status_ff;
            rsp_count_ff  <= hold_count_ff;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_count_ff, rsp_value_ff});
   assign rsp_tuser  = rsp_status_ff;

endmodule : bounded_monotonic_deque

`default_nettype wire

[rtl/bmd_check.sv]
`timescale 1ns / 1ps
`default_nettype none

module bmd_check #(
   parameter int unsigned DEPTH      = 16,
   parameter int unsigned DATA_WIDTH = 32
) (
   input wire logic                                         clock,
   input wire logic                                         reset,
   input wire logic                                         rsp_tvalid,
   input wire logic                                         rsp_tready,
   input wire logic [((DATA_WIDTH+$clog2(DEPTH+1)+7)/8)*8-1:0] rsp_tdata,
   input wire logic [1:0]                                   rsp_tuser
);
   import bmd_pkg::*;

   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] rsp_value;
   logic [CW-1:0]         rsp_count;

   assign rsp_value = rsp_tdata[DATA_WIDTH-1:0];
   assign rsp_count = rsp_tdata[DATA_WIDTH+CW-1:DATA_WIDTH];

   // a stalled response item keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response item changed while stalled");

   // an empty pop leaves nothing held and returns zero
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_EMPTY |-> rsp_count == '0 && rsp_value == '0)
      else $error("empty pop with entries or data");

   // full and duplicate push responses return no data
   a_push_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_FULL || rsp_tuser == ST_DUP) |-> rsp_value == '0)
      else $error("push response carries data");

   // a dropped duplicate leaves its equal entry held
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_DUP |-> rsp_count != '0)
      else $error("duplicate drop with empty deque");

   // no response right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule : bmd_check

bind bounded_monotonic_deque bmd_check #(
   .DEPTH      (DEPTH),
   .DATA_WIDTH (DATA_WIDTH)
) u_bmd_check (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
